// ===== rtl/core/led_ring_animation_engine_core_defines.svh =====
// Assertion macros used by the checker of the LED ring core.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef LED_RING_ANIMATION_ENGINE_CORE_DEFINES_SVH
`define LED_RING_ANIMATION_ENGINE_CORE_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define LRAE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property whose consequence must hold in the cycle after its antecedent.
`define LRAE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lrae_pkg.sv =====
package lrae_pkg;

	localparam int unsigned MAX_PIXELS_DEF   = 64;
	localparam int unsigned SINE_ENTRIES_DEF = 256;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RING_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PROGRESS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd5;

	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_SOLID   = 2'd1;
	localparam logic [1:0] MODE_BREATH  = 2'd2;
	localparam logic [1:0] MODE_ROTATE  = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	typedef struct packed {
		logic start;
		logic clear_phase;
	} breath_ctl_t;

	typedef struct packed {
		logic done;
	} breath_sts_t;

endpackage

// ===== rtl/core/led_ring_animation_engine_core.sv =====
// LED ring animation core. Each tick word on the input channel carries the
// milliseconds since the previous tick and makes the core send one pixel word
// per ring pixel, pixel 0 first, with last_pixel set on the final one; a pixel
// count of zero sends nothing. In solid and off modes and in rotating-progress
// mode the tick is registered into the emit state and the first pixel word
// then goes through the output register; after that one pixel word leaves
// per cycle while the pixel side does not stall. Breathing mode first runs
// the phase step through a bit-serial multiplier, one elapsed bit at a
// time, then updates the phase, reads the brightness table, and scales the
// three channels bit-serially before the pixel words go out. The tick side
// shows stall for the whole frame, so one tick is worked on at a time, while
// the last pixel word may still wait in the output register when the next
// tick is taken. Configuration writes are meant for the idle core; writing a
// colour channel or the mode restarts the breathing phase.
module led_ring_animation_engine_core #(
	parameter int unsigned MAX_PIXELS   = lrae_pkg::MAX_PIXELS_DEF,
	parameter int unsigned SINE_ENTRIES = lrae_pkg::SINE_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lrae_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrae_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            tick_valid,
	output logic                            tick_stall,
	input  logic [15:0]                     elapsed_ms,
	output logic                            pixel_valid,
	input  logic                            pixel_stall,
	output logic [5:0]                      pixel_index,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic                            last_pixel
);
	import lrae_pkg::*;

	// The pixel counter only has to reach the saturated pixel count.
	localparam int unsigned CNT_W = (MAX_PIXELS >= 127) ? 7 : $clog2(MAX_PIXELS + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_BREATH = 3'b010,
		S_EMIT   = 3'b100
	} state_t;

	state_t       state_q;
	color_t       color_q;
	logic [1:0]   ring_mode_q;
	logic [6:0]   progress_q;
	logic [6:0]   pixel_count_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pix_q;
	logic [13:0]      lit_limit_q;
	logic [13:0]      hundred_q;

	logic [CNT_W-1:0] count_sat;
	logic [6:0]       progress_clamped;
	logic [CNT_W+5:0] pix_ext;
	logic             tick_take;
	logic             emit_now;
	logic             pix_last;
	logic             pix_lit;
	color_t           frame_color;

	breath_ctl_t breath_ctl;
	breath_sts_t breath_sts;
	color_t      breath_color;

	logic             out_valid_q;
	logic [5:0]       out_index_q;
	color_t           out_color_q;
	logic             out_last_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q.red   <= 8'd0;
			color_q.green <= 8'd255;
			color_q.blue  <= 8'd0;
			ring_mode_q   <= MODE_SOLID;
			progress_q    <= 7'd0;
			pixel_count_q <= 7'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLOR_RED:   color_q.red   <= cfg_data;
				REG_COLOR_GREEN: color_q.green <= cfg_data;
				REG_COLOR_BLUE:  color_q.blue  <= cfg_data;
				REG_RING_MODE:   ring_mode_q   <= cfg_data[1:0];
				REG_PROGRESS:    progress_q    <= cfg_data[6:0];
				REG_PIXEL_COUNT: pixel_count_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign breath_ctl.clear_phase = cfg_we && ((cfg_index == REG_COLOR_RED)
		|| (cfg_index == REG_COLOR_GREEN) || (cfg_index == REG_COLOR_BLUE)
		|| (cfg_index == REG_RING_MODE));

	assign tick_stall = (state_q != S_IDLE);
	assign tick_take  = tick_valid && !tick_stall;

	assign breath_ctl.start = tick_take && (ring_mode_q == MODE_BREATH);

	assign count_sat = (int'(pixel_count_q) > int'(MAX_PIXELS)) ?
		CNT_W'(MAX_PIXELS) : CNT_W'(pixel_count_q);
	assign progress_clamped = (progress_q > 7'd100) ? 7'd100 : progress_q;

	lrae_breath #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_breath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (breath_ctl),
		.elapsed (elapsed_ms),
		.color   (color_q),
		.sts     (breath_sts),
		.scaled  (breath_color)
	);

	// Pixel i is lit in rotating mode when 100 * i <= progress * count, which
	// is the same as i <= floor(progress * count / 100).
	assign pix_lit     = (ring_mode_q != MODE_ROTATE) || (hundred_q <= lit_limit_q);
	assign pix_last    = ((pix_q + CNT_W'(1)) == count_q);
	assign frame_color = (ring_mode_q == MODE_BREATH) ? breath_color : color_q;
	assign emit_now    = (state_q == S_EMIT) && (!out_valid_q || !pixel_stall);
	assign pix_ext     = {6'd0, pix_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (tick_take) begin
						if (ring_mode_q == MODE_BREATH) begin
							state_q <= S_BREATH;
						end else if (count_sat != '0) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_BREATH: begin
					if (breath_sts.done) begin
						state_q <= (count_q != '0) ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (emit_now && pix_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			count_q     <= count_sat;
			lit_limit_q <= 14'(progress_clamped) * 14'(count_sat);
			pix_q       <= '0;
			hundred_q   <= '0;
		end else if (emit_now) begin
			pix_q     <= pix_q + CNT_W'(1);
			hundred_q <= hundred_q + 14'd100;
		end
	end

	// Output register: a waiting pixel word does not hold up the tick side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (!pixel_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			out_index_q <= pix_ext[5:0];
			out_color_q <= pix_lit ? frame_color : '0;
			out_last_q  <= pix_last;
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel_index = out_index_q;
	assign red         = out_color_q.red;
	assign green       = out_color_q.green;
	assign blue        = out_color_q.blue;
	assign last_pixel  = out_last_q;

endmodule

// ===== rtl/core/lrae_breath.sv =====
module lrae_breath #(
	parameter int unsigned SINE_ENTRIES = lrae_pkg::SINE_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrae_pkg::breath_ctl_t ctl,
	input  logic [15:0]           elapsed,
	input  lrae_pkg::color_t      color,
	output lrae_pkg::breath_sts_t sts,
	output lrae_pkg::color_t      scaled
);
	import lrae_pkg::*;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned FACTOR_BASE = 64'd77;
	localparam longint unsigned FACTOR_SPAN = 64'd179;
	localparam logic [20:0]     PHASE_STEP  = 21'd1367131;

	localparam int unsigned IDX_W = $clog2(SINE_ENTRIES);
	localparam int unsigned NW    = $clog2(SINE_ENTRIES + 1);
	localparam logic [NW-1:0] ENTRIES_C = NW'(SINE_ENTRIES);

	typedef logic [7:0] rom_t [SINE_ENTRIES];

	// Brightness factor 77 + 179 * (1 + sin) / 2 in Q8 for one table entry.
	// The Taylor terms x^3/3!, x^5/5!, ... are built from the previous term,
	// so each one divides by (2k)(2k+1) for k = 1 to 5.
	function automatic logic [7:0] factor_of(longint unsigned idx);
		longint unsigned q;
		longint unsigned rem;
		longint unsigned m;
		longint unsigned x;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned r;
		longint unsigned base;
		q = (4 * idx) / SINE_ENTRIES;
		rem = 4 * idx - q * SINE_ENTRIES;
		m = q[0] ? SINE_ENTRIES - rem : rem;
		x = (m * HALF_PI_Q30) / SINE_ENTRIES;
		term = x;
		sum = x;
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd6;
		sum = (term > sum) ? 64'd0 : sum - term;
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd20;
		sum = sum + term;
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd42;
		sum = (term > sum) ? 64'd0 : sum - term;
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd72;
		sum = sum + term;
		term = (term * x) >> 30;
		term = (term * x) >> 30;
		term = term / 64'd110;
		sum = (term > sum) ? 64'd0 : sum - term;
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		r = (sum + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		base = (q >= 2) ? 64'd32768 - r : 64'd32768 + r;
		return 8'(FACTOR_BASE + ((FACTOR_SPAN * base) >> 16));
	endfunction

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			t[i] = factor_of(longint'(i));
		end
		return t;
	endfunction

	localparam rom_t FACTOR_ROM = build_rom();

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_MUL   = 5'b00010,
		B_ADD   = 5'b00100,
		B_ROM   = 5'b01000,
		B_SCALE = 5'b10000
	} bstate_t;

	bstate_t      state_q;
	logic [3:0]   bit_q;
	logic [15:0]  phase_q;
	logic [15:0]  mul_sh_q;
	logic [20:0]  step_acc_q;
	logic [21:0]  step_sum;
	logic [7:0]   f_sh_q;
	color_t       chan_q;
	color_t       acc_q;
	logic [8:0]   sum_r;
	logic [8:0]   sum_g;
	logic [8:0]   sum_b;
	logic [15+NW:0] idx_prod;
	logic [IDX_W-1:0] rom_idx;

	// One multiplier bit per cycle; the low product bits fall off the bottom.
	assign step_sum = {1'b0, step_acc_q} + (mul_sh_q[0] ? {1'b0, PHASE_STEP} : 22'd0);

	assign sum_r = {1'b0, acc_q.red}   + (f_sh_q[0] ? {1'b0, chan_q.red}   : 9'd0);
	assign sum_g = {1'b0, acc_q.green} + (f_sh_q[0] ? {1'b0, chan_q.green} : 9'd0);
	assign sum_b = {1'b0, acc_q.blue}  + (f_sh_q[0] ? {1'b0, chan_q.blue}  : 9'd0);

	assign idx_prod = (16 + NW)'(phase_q) * (16 + NW)'(ENTRIES_C);
	assign rom_idx  = idx_prod[15+IDX_W:16];

	assign sts.done = (state_q == B_SCALE) && (bit_q == 4'd7);
	assign scaled   = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			bit_q   <= '0;
			phase_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (ctl.clear_phase) begin
						phase_q <= '0;
					end
					if (ctl.start) begin
						bit_q   <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					bit_q <= bit_q + 4'd1;
					if (bit_q == 4'd15) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: begin
					phase_q <= phase_q + step_acc_q[15:0];
					state_q <= B_ROM;
				end
				B_ROM: begin
					bit_q   <= '0;
					state_q <= B_SCALE;
				end
				B_SCALE: begin
					bit_q <= bit_q + 4'd1;
					if (bit_q == 4'd7) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				mul_sh_q   <= elapsed;
				step_acc_q <= '0;
				chan_q     <= color;
			end
			B_MUL: begin
				mul_sh_q   <= mul_sh_q >> 1;
				step_acc_q <= step_sum[21:1];
			end
			B_ROM: begin
				f_sh_q <= FACTOR_ROM[rom_idx];
				acc_q  <= '0;
			end
			B_SCALE: begin
				f_sh_q      <= f_sh_q >> 1;
				acc_q.red   <= sum_r[8:1];
				acc_q.green <= sum_g[8:1];
				acc_q.blue  <= sum_b[8:1];
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/lrae_checker.sv =====
`include "led_ring_animation_engine_core_defines.svh"

module lrae_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tick_stall,
	input logic       pixel_valid,
	input logic       pixel_stall,
	input logic [5:0] pixel_index,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       last_pixel
);

	// A stalled pixel word stays in place.
	`LRAE_ASSERT_NEXT(a_pixel_hold, pixel_valid && pixel_stall, pixel_valid && $stable(pixel_index) && $stable(red) && $stable(green) && $stable(blue) && $stable(last_pixel), "stalled pixel word changed")

	// Within a frame the next pixel word follows at once, one index higher.
	`LRAE_ASSERT_NEXT(a_pixel_seq, pixel_valid && !pixel_stall && !last_pixel, pixel_valid && (pixel_index == $past(pixel_index) + 6'd1), "pixel words out of sequence")

	// No new tick is taken while a frame is still unfinished.
	`LRAE_ASSERT_NOW(a_tick_busy, pixel_valid && !last_pixel, tick_stall, "tick taken during a frame")

	// The first word of a frame is pixel 0.
	`LRAE_ASSERT_NEXT(a_frame_start, pixel_valid && !pixel_stall && last_pixel, !pixel_valid || (pixel_index == 6'd0), "frame did not start at pixel 0")

endmodule

bind led_ring_animation_engine_core lrae_checker u_lrae_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the LED ring animation core.
//
// An initial block works through a list of register settings. Each setting is
// written while the core is idle, and then a batch of tick words goes into a
// queue. A clocked driver takes tick words from that queue and offers them on
// the tick channel. Every tick word the core accepts goes through a predictor,
// which keeps its own copy of the registers and of the breathing phase and
// appends the pixel words the core should send. A clocked monitor takes every
// pixel word the core sends and compares it, field by field, with the oldest
// predicted word.
module tb;
	import lrae_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_TICKS  = 470;
	localparam int DRAIN_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_AFTER    = 400;
	localparam int HOLD_CYCLES   = 600;

	localparam int unsigned MAX_PIX = MAX_PIXELS_DEF;
	localparam int unsigned SINE_N  = SINE_ENTRIES_DEF;

	// Fixed-point constants of the breathing arithmetic.
	localparam longint unsigned PHASE_STEP_Q16 = 64'd1367131;
	localparam longint unsigned HALF_PI_Q30    = 64'd1686629713;
	localparam longint unsigned ONE_Q30        = 64'd1073741824;
	localparam longint unsigned ROUND_Q15      = 64'd16384;
	localparam longint unsigned MAX_Q15        = 64'd32767;
	localparam int unsigned     SINE_MID       = 32768;
	localparam int unsigned     FACTOR_BASE_Q8 = 77;
	localparam int unsigned     FACTOR_SPAN_Q8 = 179;
	localparam int unsigned     FULL_PERCENT   = 100;

	// Indexes beyond the register file; the core must ignore writes to them.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [5:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_word_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  tick_valid  = 1'b0;
	logic                  tick_stall;
	logic [15:0]           elapsed_ms  = '0;
	logic                  pixel_valid;
	logic                  pixel_stall = 1'b0;
	logic [5:0]            pixel_index;
	logic [7:0]            red;
	logic [7:0]            green;
	logic [7:0]            blue;
	logic                  last_pixel;

	// Predictor copy of the register file and of the breathing phase.
	logic [7:0]  cfg_red      = 8'd0;
	logic [7:0]  cfg_green    = 8'd255;
	logic [7:0]  cfg_blue     = 8'd0;
	logic [1:0]  cfg_mode     = MODE_SOLID;
	logic [6:0]  cfg_progress = 7'd0;
	logic [6:0]  cfg_count    = 7'd16;
	logic [15:0] phase_acc    = 16'd0;

	// First quadrant of the sine, sin(m / SINE_N * pi / 2) in Q15.
	logic [15:0] quarter_sine_q15 [0:SINE_N];

	logic [15:0] pending_ticks [$];
	pixel_word_t expected_pixels [$];

	int unsigned tx_idle_pct = 20;
	int unsigned rx_idle_pct = 80;
	int unsigned ticks_taken = 0;
	int unsigned hold_left   = 0;
	logic        hold_used   = 1'b0;
	int unsigned error_count = 0;

	led_ring_animation_engine_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.elapsed_ms  (elapsed_ms),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_pixel  (last_pixel)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The quarter-wave table is built once at time zero. Each entry is a Taylor
	// series to x^11 in Q30, with the odd terms subtracted without going below
	// zero, then rounded half up to Q15 and capped just under one.
	initial begin : sine_rom_build
		longint unsigned x;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned rounded;
		for (int m = 0; m <= SINE_N; m++) begin
			x = m;
			x = (x * HALF_PI_Q30) / SINE_N;
			term = x;
			sum = x;
			for (int k = 1; k <= 5; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / ((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					sum = (term > sum) ? 64'd0 : sum - term;
				end else begin
					sum = sum + term;
				end
			end
			if (sum > ONE_Q30)
				sum = ONE_Q30;
			rounded = (sum + ROUND_Q15) >> 15;
			if (rounded > MAX_Q15)
				rounded = MAX_Q15;
			quarter_sine_q15[m] = rounded[15:0];
		end
	end

	// Works out the frame that one accepted tick word must produce. In
	// breathing mode the phase moves first and the brightness factor is then
	// taken from the quarter-wave table by quadrant symmetry. In rotating mode
	// the pixels up to floor(progress * count / 100) are lit and the rest are
	// black. Off and solid send the configured color as it is.
	function automatic void predict_frame(input logic [15:0] ms);
		longint unsigned step;
		int unsigned n;
		int unsigned lit_top;
		int unsigned idx;
		int unsigned q;
		int unsigned rem;
		int unsigned m;
		int unsigned base;
		int unsigned f;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic lit;
		pixel_word_t w;
		n = (cfg_count > MAX_PIX) ? MAX_PIX : cfg_count;
		r = cfg_red;
		g = cfg_green;
		b = cfg_blue;
		lit_top = 0;
		if (cfg_mode == MODE_BREATH) begin
			step = ms;
			step = (step * PHASE_STEP_Q16) >> 16;
			phase_acc = phase_acc + step[15:0];
			idx = phase_acc;
			idx = (idx * SINE_N) >> 16;
			q = (4 * idx) / SINE_N;
			rem = 4 * idx - q * SINE_N;
			m = (q % 2 == 1) ? SINE_N - rem : rem;
			base = (q >= 2) ? SINE_MID - quarter_sine_q15[m] : SINE_MID + quarter_sine_q15[m];
			f = FACTOR_BASE_Q8 + ((FACTOR_SPAN_Q8 * base) >> 16);
			r = 8'((cfg_red * f) >> 8);
			g = 8'((cfg_green * f) >> 8);
			b = 8'((cfg_blue * f) >> 8);
		end else if (cfg_mode == MODE_ROTATE) begin
			lit_top = ((cfg_progress > FULL_PERCENT) ? FULL_PERCENT : cfg_progress) * n
				/ FULL_PERCENT;
		end
		for (int i = 0; i < n; i++) begin
			lit = (cfg_mode != MODE_ROTATE) || (i <= lit_top);
			w.index = 6'(i);
			w.red = lit ? r : 8'd0;
			w.green = lit ? g : 8'd0;
			w.blue = lit ? b : 8'd0;
			w.last = (i + 1 == n);
			expected_pixels.push_back(w);
		end
	endfunction

	// Drives one register write at the next edge and mirrors it in the
	// predictor. Writing a color channel or the mode clears the phase.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_COLOR_RED: begin
				cfg_red = data;
				phase_acc = '0;
			end
			REG_COLOR_GREEN: begin
				cfg_green = data;
				phase_acc = '0;
			end
			REG_COLOR_BLUE: begin
				cfg_blue = data;
				phase_acc = '0;
			end
			REG_RING_MODE: begin
				cfg_mode = data[1:0];
				phase_acc = '0;
			end
			REG_PROGRESS: cfg_progress = data[6:0];
			REG_PIXEL_COUNT: cfg_count = data[6:0];
			default: ;
		endcase
	endtask

	// Lets the last write land, drops the write enable and moves to the falling
	// edge, so that tick words queued next never race the driver.
	task automatic commit_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until every queued tick word has been taken and every predicted
	// pixel word has come out. A tick with a pixel count of zero sends nothing,
	// so the core may still be busy at that point; the settle time covers the
	// longest breathing frame before any register is touched again.
	task automatic wait_idle();
		int unsigned guard;
		guard = 0;
		while (pending_ticks.size() != 0 || tick_valid)
			@(posedge clk);
		while (expected_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Color channels lean on the two extremes half of the time.
	function automatic logic [7:0] rand_channel();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Tick driver. A word is taken at an edge where valid is high and the core
	// does not stall. Only then, or while valid is low, is a new word offered
	// or valid dropped for an idle cycle; a stalled word never changes.
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_valid <= 1'b0;
		end else begin
			if (tick_valid && !tick_stall) begin
				predict_frame(elapsed_ms);
				ticks_taken <= ticks_taken + 1;
			end
			if (!tick_valid || !tick_stall) begin
				if (pending_ticks.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					tick_valid <= 1'b1;
					elapsed_ms <= pending_ticks.pop_front();
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off on the pixel side, once, late in the run while the tick
	// side keeps offering words. The core has to back up and stall its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (!hold_used && ticks_taken >= HOLD_AFTER && pixel_valid) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Pixel-side stall: random idling plus the long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			pixel_stall <= 1'b0;
		end else begin
			pixel_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Pixel monitor: each word taken is checked against the oldest prediction.
	always @(posedge clk) begin : pixel_check
		pixel_word_t want;
		if (arst_n && pixel_valid && !pixel_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel word with no frame pending: pixel_index %0d", pixel_index);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_index !== want.index) begin
					$error("pixel_index: expected %0d, got %0d", want.index, pixel_index);
					error_count++;
				end
				if (red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, red);
					error_count++;
				end
				if (green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, green);
					error_count++;
				end
				if (blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, blue);
					error_count++;
				end
				if (last_pixel !== want.last) begin
					$error("last_pixel: expected %0d, got %0d", want.last, last_pixel);
					error_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned sent;
		int unsigned plen;
		int unsigned pick;
		logic [1:0] mode;
		logic [6:0] value7;
		logic [15:0] ms;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The reset values first: solid green on 16 pixels,
		// with the shortest and the longest elapsed time.
		@(negedge clk);
		pending_ticks.push_back(16'h0000);
		pending_ticks.push_back(16'hFFFF);
		wait_idle();

		// Off mode still sends the configured color, here on a single pixel.
		write_reg(REG_COLOR_RED, 8'hFF);
		write_reg(REG_COLOR_GREEN, 8'h00);
		write_reg(REG_COLOR_BLUE, 8'hFF);
		write_reg(REG_RING_MODE, {6'd0, MODE_OFF});
		write_reg(REG_PIXEL_COUNT, 8'd1);
		commit_writes();
		pending_ticks.push_back(16'd100);
		wait_idle();

		// A pixel count of zero gives an empty frame.
		write_reg(REG_RING_MODE, {6'd0, MODE_SOLID});
		write_reg(REG_PIXEL_COUNT, 8'd0);
		commit_writes();
		pending_ticks.push_back(16'd5);
		wait_idle();

		// Full ring.
		write_reg(REG_PIXEL_COUNT, 8'd64);
		commit_writes();
		pending_ticks.push_back(16'hAAAA);
		wait_idle();

		// Rotating with zero progress lights pixel 0 only. The count of 127,
		// with the unused top data bit set, saturates to the ring size.
		write_reg(REG_RING_MODE, {6'd0, MODE_ROTATE});
		write_reg(REG_PROGRESS, 8'd0);
		write_reg(REG_PIXEL_COUNT, 8'hFF);
		commit_writes();
		pending_ticks.push_back(16'h5555);
		wait_idle();

		// Full progress, then progress above 100 which clamps, with the top
		// data bit set on the first write.
		write_reg(REG_PROGRESS, 8'hE4);
		write_reg(REG_PIXEL_COUNT, 8'd64);
		commit_writes();
		pending_ticks.push_back(16'd1);
		wait_idle();
		write_reg(REG_PROGRESS, 8'h7F);
		commit_writes();
		pending_ticks.push_back(16'd2);
		wait_idle();
		write_reg(REG_PROGRESS, 8'd50);
		write_reg(REG_PIXEL_COUNT, 8'd7);
		commit_writes();
		pending_ticks.push_back(16'd3);
		wait_idle();
		write_reg(REG_PROGRESS, 8'd99);
		write_reg(REG_PIXEL_COUNT, 8'd1);
		commit_writes();
		pending_ticks.push_back(16'd4);
		wait_idle();

		// Breathing on white. The mode write carries junk in the upper bits.
		// A step of about 753 ms is roughly a quarter turn, so the frames walk
		// through the first three quadrants of the sine.
		write_reg(REG_COLOR_RED, 8'hFF);
		write_reg(REG_COLOR_GREEN, 8'hFF);
		write_reg(REG_COLOR_BLUE, 8'hFF);
		write_reg(REG_RING_MODE, {6'h3F, MODE_BREATH});
		write_reg(REG_PIXEL_COUNT, 8'd3);
		commit_writes();
		pending_ticks.push_back(16'd0);
		pending_ticks.push_back(16'd1);
		pending_ticks.push_back(16'd753);
		pending_ticks.push_back(16'd753);
		pending_ticks.push_back(16'd753);
		pending_ticks.push_back(16'hFFFF);
		wait_idle();

		// Empty breathing frames still move the phase, and writing the count
		// or the progress must not clear it.
		write_reg(REG_PIXEL_COUNT, 8'd0);
		commit_writes();
		pending_ticks.push_back(16'd1000);
		pending_ticks.push_back(16'd2000);
		wait_idle();
		write_reg(REG_PIXEL_COUNT, 8'd5);
		write_reg(REG_PROGRESS, 8'd33);
		commit_writes();
		pending_ticks.push_back(16'd400);
		wait_idle();

		// Writes to the two spare indexes are ignored; a mid-level green.
		write_reg(REG_SPARE_LO, 8'hFF);
		write_reg(REG_SPARE_HI, 8'h00);
		write_reg(REG_COLOR_GREEN, 8'h80);
		commit_writes();
		pending_ticks.push_back(16'd300);
		wait_idle();

		// Random part. Each batch may get a new setting; the idling pattern
		// changes by thirds, and the last third runs with no idling at all.
		sent = 0;
		while (sent < RANDOM_TICKS) begin
			if ($urandom_range(3) != 0) begin
				write_reg(REG_COLOR_RED, rand_channel());
				write_reg(REG_COLOR_GREEN, rand_channel());
				write_reg(REG_COLOR_BLUE, rand_channel());
				pick = $urandom_range(9);
				if (pick == 0)
					mode = MODE_OFF;
				else if (pick <= 2)
					mode = MODE_SOLID;
				else if (pick <= 6)
					mode = MODE_BREATH;
				else
					mode = MODE_ROTATE;
				write_reg(REG_RING_MODE, {6'($urandom_range(63)), mode});
			end
			// Count and progress are left alone now and then; skipping the color
			// and mode writes above lets the breathing phase run on across batches.
			if ($urandom_range(4) != 0) begin
				pick = $urandom_range(9);
				if (pick == 0)
					value7 = 7'd0;
				else if (pick == 1)
					value7 = 7'd100;
				else if (pick == 2)
					value7 = 7'($urandom_range(127, 101));
				else
					value7 = 7'($urandom_range(100));
				write_reg(REG_PROGRESS, {1'($urandom_range(1)), value7});
				pick = $urandom_range(19);
				if (pick <= 1)
					value7 = 7'd0;
				else if (pick == 2)
					value7 = 7'd64;
				else if (pick <= 4)
					value7 = 7'($urandom_range(127, 65));
				else if (pick <= 6)
					value7 = 7'($urandom_range(63, 17));
				else
					value7 = 7'($urandom_range(16, 1));
				write_reg(REG_PIXEL_COUNT, {1'($urandom_range(1)), value7});
			end
			if ($urandom_range(7) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
					8'($urandom_range(255)));
			commit_writes();

			if (sent < RANDOM_TICKS / 3) begin
				tx_idle_pct = 20;
				rx_idle_pct = 80;
			end else if (sent < 2 * RANDOM_TICKS / 3) begin
				tx_idle_pct = 80;
				rx_idle_pct = 20;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			plen = (cfg_mode == MODE_BREATH) ? $urandom_range(40, 10) : $urandom_range(20, 5);
			if (plen > RANDOM_TICKS - sent)
				plen = RANDOM_TICKS - sent;
			repeat (plen) begin
				pick = $urandom_range(19);
				if (pick <= 1)
					ms = 16'h0000;
				else if (pick == 2)
					ms = 16'hFFFF;
				else if (pick <= 11)
					ms = 16'($urandom_range(2000));
				else
					ms = 16'($urandom_range(16'hFFFF));
				pending_ticks.push_back(ms);
			end
			sent += plen;
			wait_idle();
		end

		if (expected_pixels.size() != 0) begin
			$error("%0d predicted pixel words never came out", expected_pixels.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("led_ring_animation_engine_core test passed");
		end else begin
			$display("led_ring_animation_engine_core test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10ms;
		$display("led_ring_animation_engine_core test failed");
		$finish;
	end

endmodule
